FILE: rtl/core/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Used by the front decoder, the job queue, the back end and the top level.
package u2u_pkg;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_LEAD  = 3'd1,
    ERR_CONT  = 3'd2,
    ERR_TRUNC = 3'd3,
    ERR_SURR  = 3'd4,
    ERR_RANGE = 3'd5
  } err_t;

  // One decoded item handed from the front to the back.
  typedef struct packed {
    logic [20:0] cp;
    err_t        err;
    logic        last;
  } job_t;

  typedef enum logic {
    PH_FIRST = 1'b0,
    PH_TRAIL = 1'b1
  } back_phase_t;

  localparam logic [20:0] SURR_LOW    = 21'h00d800;
  localparam logic [20:0] SURR_HIGH   = 21'h00dfff;
  localparam logic [20:0] CP_MAX      = 21'h10ffff;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [15:0] LEAD_SURR   = 16'hd800;
  localparam logic [15:0] TRAIL_SURR  = 16'hdc00;
  localparam int          TDATA_OUT_W = 24;

endpackage

FILE: rtl/core/u2u_front.sv
// Front decoder: tracks the open UTF-8 sequence and turns accepted bytes
// into jobs (a completed code point or an error). Depends on u2u_pkg.
module u2u_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     byte_value,
  input  logic           end_of_string,
  output logic           job_valid,
  output u2u_pkg::job_t  job
);
  import u2u_pkg::*;

  logic [1:0]  remaining;
  logic [1:0]  remaining_next;
  logic [20:0] acc;
  logic [20:0] acc_next;
  logic [1:0]  rem_dec;
  logic [20:0] acc_shift;

  assign rem_dec   = remaining - 2'd1;
  assign acc_shift = {acc[14:0], byte_value[5:0]};

  always_comb begin
    job_valid      = 1'b0;
    job.cp         = '0;
    job.err        = ERR_NONE;
    job.last       = end_of_string;
    remaining_next = remaining;
    acc_next       = acc;
    if (remaining == 2'd0) begin
      if (!byte_value[7]) begin
        job_valid = 1'b1;
        job.cp    = {13'd0, byte_value};
      end else if (byte_value[7:5] == 3'b110) begin
        acc_next       = {16'd0, byte_value[4:0]};
        remaining_next = 2'd1;
      end else if (byte_value[7:4] == 4'b1110) begin
        acc_next       = {17'd0, byte_value[3:0]};
        remaining_next = 2'd2;
      end else if (byte_value[7:3] == 5'b11110) begin
        acc_next       = {18'd0, byte_value[2:0]};
        remaining_next = 2'd3;
      end else begin
        job_valid = 1'b1;
        job.err   = ERR_LEAD;
      end
      // A lead byte that opens a sequence on the string's last byte is cut off.
      if (remaining_next != 2'd0 && end_of_string) begin
        job_valid      = 1'b1;
        job.err        = ERR_TRUNC;
        remaining_next = 2'd0;
        acc_next       = '0;
      end
    end else begin
      remaining_next = rem_dec;
      if (end_of_string && rem_dec != 2'd0) begin
        job_valid      = 1'b1;
        job.err        = ERR_TRUNC;
        remaining_next = 2'd0;
        acc_next       = '0;
      end else if (byte_value[7:6] != 2'b10) begin
        job_valid      = 1'b1;
        job.err        = ERR_CONT;
        remaining_next = 2'd0;
        acc_next       = '0;
      end else if (rem_dec == 2'd0) begin
        job_valid = 1'b1;
        job.cp    = acc_shift;
        acc_next  = '0;
      end else begin
        acc_next = acc_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      acc       <= '0;
    end else if (accept) begin
      remaining <= remaining_next;
      acc       <= acc_next;
    end
  end

endmodule

FILE: rtl/core/u2u_queue.sv
// Short job queue between the front decoder and the back end.
// Depends on u2u_pkg for the job type.
module u2u_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u2u_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output u2u_pkg::job_t  head_job,
  output logic           empty
);
  import u2u_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW + 1)'(DEPTH));
  assign empty    = (count == '0);
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/u2u_back.sv
// Back end: range-checks each completed code point, splits supplementary
// ones into a surrogate pair and drives the output register. Depends on u2u_pkg.
module u2u_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  u2u_pkg::job_t                      head_job,
  output logic                               pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [u2u_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [15:0] code_unit, [18:16] error_code
  output logic                               m_tuser,   // last_in_run
  output logic                               m_tlast    // string_done
);
  import u2u_pkg::*;

  back_phase_t phase;
  back_phase_t phase_next;
  logic        load;
  logic        is_pair;
  logic [19:0] supp;
  logic [15:0] unit;
  err_t        err;
  logic        final_res;

  assign load = head_valid && (!m_tvalid || m_tready);
  assign supp = 20'(head_job.cp - SUPP_BASE);

  always_comb begin
    is_pair = 1'b0;
    unit    = '0;
    err     = head_job.err;
    if (head_job.err == ERR_NONE) begin
      if (head_job.cp >= SURR_LOW && head_job.cp <= SURR_HIGH) begin
        err = ERR_SURR;
      end else if (head_job.cp > CP_MAX) begin
        err = ERR_RANGE;
      end else if (head_job.cp < SUPP_BASE) begin
        unit = head_job.cp[15:0];
      end else begin
        is_pair = 1'b1;
        unit    = (phase == PH_FIRST) ? (LEAD_SURR | {6'd0, supp[19:10]})
                                      : (TRAIL_SURR | {6'd0, supp[9:0]});
      end
    end
  end

  // Next state: a pair holds the job for one extra transaction.
  always_comb begin
    phase_next = phase;
    if (load) begin
      case (phase)
        PH_FIRST: phase_next = is_pair ? PH_TRAIL : PH_FIRST;
        PH_TRAIL: phase_next = PH_FIRST;
        default:  phase_next = PH_FIRST;
      endcase
    end
  end

  always_comb begin
    case (phase)
      PH_FIRST: final_res = !is_pair;
      PH_TRAIL: final_res = 1'b1;
      default:  final_res = 1'b1;
    endcase
    pop = load && final_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {(TDATA_OUT_W - 19)'(0), err, unit};
      m_tuser <= final_res;
      m_tlast <= final_res && head_job.last;
    end
  end

endmodule

FILE: rtl/core/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
// Instantiates u2u_front, u2u_queue and u2u_back; types come from u2u_pkg.
//
// Bytes enter one per cycle on the s_ side; s_tlast marks the last byte of a
// string. Each completed character gives one UTF-16 unit, or a lead and trail
// surrogate in two transactions for code points above the BMP; every error
// gives a single result with a zero unit and a nonzero error code, after which
// decoding restarts at the next byte. m_tuser marks the final result caused by
// a byte and m_tlast the final result of a string. A byte's result is written
// into the job queue and then loaded into the output register before it is
// presented. Input is taken at one byte per cycle while the
// QUEUE_DEPTH-entry job queue has room; the output register issues one result
// per cycle while m_tready is high, so a surrogate pair gives two results,
// which the queue absorbs since a pair needs four input bytes.
module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] byte_value
  input  logic                            s_tlast,   // end_of_string
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [u2u_pkg::TDATA_OUT_W-1:0] m_tdata,   // [15:0] code_unit, [18:16] error_code
  output logic                            m_tuser,   // last_in_run
  output logic                            m_tlast    // string_done
);
  import u2u_pkg::*;

  logic accept;
  logic job_valid;
  job_t job;
  logic push;
  logic full;
  logic pop;
  logic empty;
  job_t head_job;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && job_valid;

  u2u_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_value    (s_tdata),
    .end_of_string (s_tlast),
    .job_valid     (job_valid),
    .job           (job)
  );

  u2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  u2u_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!empty),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // The back end only retires jobs that are present.
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job retired from an empty queue");

  // The end of a string can only fall on the final result of a byte.
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && !m_tuser) |-> !m_tlast)
    else $error("string end flagged on a non-final result");

  // Error results carry a zero unit and are never split.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tdata[18:16] != ERR_NONE) |-> (m_tdata[15:0] == 16'd0 && m_tuser))
    else $error("malformed error result");

  // A non-final result is always the lead half of a surrogate pair.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tuser) |-> (m_tdata[15:10] == 6'b110110))
    else $error("non-final result is not a lead surrogate");

endmodule

FILE: tb/utf8_to_utf16_transcoder_tb.sv
// Self-checking testbench for utf8_to_utf16_transcoder.
// Streams UTF-8 strings into the block and checks each UTF-16 result against a
// decoder model or a directed row; depends only on u2u_pkg and the transcoder RTL.
module utf8_to_utf16_transcoder_tb;
  import u2u_pkg::*;

  typedef struct packed {
    logic [15:0] code_unit;
    err_t        err;
    logic        run_last;
    logic        str_done;
  } utf16_res_t;

  // One directed row; rows with known_res set carry their single expected result.
  typedef struct packed {
    logic [7:0]  byte_val;
    logic        eos;
    logic        known_res;
    logic [15:0] exp_unit;
    err_t        exp_err;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 26;
  localparam int PHASE_BYTES  = 480;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'h00;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  utf16_res_t utf16_expect_q[$];
  dir_row_t   dir_rows [0:NUM_DIR_ROWS-1];

  // Decoder state mirrored from the block.
  logic [20:0] cp_acc = '0;
  logic [1:0]  cont_left = '0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int fail_cnt = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int results_seen = 0;
  int error_results = 0;
  int pairs_seen = 0;

  utf8_to_utf16_transcoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic void push_expect(input logic [15:0] cu, input err_t err,
                                      input logic run_last, input logic str_done);
    utf16_res_t r;
    r.code_unit = cu;
    r.err       = err;
    r.run_last  = run_last;
    r.str_done  = str_done;
    utf16_expect_q.push_back(r);
  endfunction

  // Advances the decoder by one byte and, if record is set, queues the results.
  function automatic void decode_utf8_byte(input logic [7:0] b, input logic eos,
                                           input logic record);
    logic [20:0] cp;
    logic [20:0] off;
    err_t        err;
    logic        done;
    err  = ERR_NONE;
    done = 1'b0;
    cp   = '0;
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        cp   = {13'd0, b};
        done = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        cp_acc    = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc    = {17'd0, b[3:0]};
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc    = {18'd0, b[2:0]};
        cont_left = 2'd3;
      end else begin
        err = ERR_LEAD;
      end
      if (cont_left != 2'd0 && eos) begin
        err       = ERR_TRUNC;
        cp_acc    = '0;
        cont_left = 2'd0;
      end
    end else begin
      cont_left = cont_left - 2'd1;
      // A string that ends mid-sequence is reported as truncated, even if the
      // final byte is not a continuation byte either.
      if (eos && cont_left != 2'd0) begin
        err       = ERR_TRUNC;
        cp_acc    = '0;
        cont_left = 2'd0;
      end else if (b[7:6] != 2'b10) begin
        err       = ERR_CONT;
        cp_acc    = '0;
        cont_left = 2'd0;
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        if (cont_left == 2'd0) begin
          cp     = cp_acc;
          done   = 1'b1;
          cp_acc = '0;
        end
      end
    end
    if (done) begin
      if (cp >= SURR_LOW && cp <= SURR_HIGH) err = ERR_SURR;
      else if (cp > CP_MAX) err = ERR_RANGE;
    end
    if (record) begin
      if (err != ERR_NONE) begin
        push_expect(16'h0000, err, 1'b1, eos);
      end else if (done && cp < SUPP_BASE) begin
        push_expect(cp[15:0], ERR_NONE, 1'b1, eos);
      end else if (done) begin
        off = cp - SUPP_BASE;
        push_expect(LEAD_SURR + {6'd0, off[19:10]}, ERR_NONE, 1'b0, 1'b0);
        push_expect(TRAIL_SURR + {6'd0, off[9:0]}, ERR_NONE, 1'b1, eos);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic record);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_utf8_byte(b, eos, record);
    bytes_sent++;
  endtask

  // Mostly well-formed characters of every length, with stray bytes, broken
  // continuations and strings cut off in the middle of a character.
  task automatic send_random_string();
    logic [7:0] str_q[$];
    logic [7:0] r;
    int         nchar;
    int         len;
    int         keep;
    int         k;
    nchar = $urandom_range(1, 6);
    repeat (nchar) begin
      case ($urandom_range(0, 9))
        0, 1, 2: len = 1;
        3, 4:    len = 2;
        5, 6:    len = 3;
        default: len = 4;
      endcase
      r = 8'($urandom);
      case (len)
        1:       str_q.push_back({1'b0, r[6:0]});
        2:       str_q.push_back({3'b110, r[4:0]});
        3:       str_q.push_back({4'b1110, r[3:0]});
        default: begin
          if ($urandom_range(0, 3) == 0) str_q.push_back({5'b11110, r[2:0]});
          else str_q.push_back(8'hf0 + 8'($urandom_range(0, 4)));
        end
      endcase
      for (k = 1; k < len; k++) begin
        r = 8'($urandom);
        if ($urandom_range(0, 11) == 0) str_q.push_back(r);
        else str_q.push_back({2'b10, r[5:0]});
      end
      if ($urandom_range(0, 9) == 0) begin
        r = 8'($urandom);
        str_q.push_back(r);
      end
    end
    keep = str_q.size();
    if ($urandom_range(0, 7) == 0) keep = $urandom_range(1, str_q.size());
    for (k = 0; k < keep; k++) send_byte(str_q[k], k == keep - 1, 1'b1);
    strings_sent++;
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    utf16_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tdata[18:16] != ERR_NONE) error_results++;
      else if (m_tdata[15:10] == 6'b110110) pairs_seen++;
      if (utf16_expect_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result unit=%h err=%0d last=%b done=%b",
                 $time, m_tdata[15:0], m_tdata[18:16], m_tuser, m_tlast);
      end else begin
        e = utf16_expect_q.pop_front();
        if (m_tdata[15:0] != e.code_unit || m_tdata[18:16] != e.err ||
            m_tuser != e.run_last || m_tlast != e.str_done) begin
          fail_cnt++;
          $display({"%0t: mismatch expected unit=%h err=%0d last=%b done=%b,",
                    " got unit=%h err=%0d last=%b done=%b"},
                   $time, e.code_unit, e.err, e.run_last, e.str_done,
                   m_tdata[15:0], m_tdata[18:16], m_tuser, m_tlast);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int i;
    int ph;
    int k;
    int phase_end;
    dir_rows[0]  = '{8'h00, 1'b0, 1'b1, 16'h0000, ERR_NONE};
    dir_rows[1]  = '{8'h7f, 1'b1, 1'b1, 16'h007f, ERR_NONE};
    dir_rows[2]  = '{8'h80, 1'b0, 1'b1, 16'h0000, ERR_LEAD};
    dir_rows[3]  = '{8'hff, 1'b0, 1'b1, 16'h0000, ERR_LEAD};
    dir_rows[4]  = '{8'hf8, 1'b1, 1'b1, 16'h0000, ERR_LEAD};
    dir_rows[5]  = '{8'hc2, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[6]  = '{8'ha9, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[7]  = '{8'he2, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[8]  = '{8'h82, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[9]  = '{8'hac, 1'b1, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[10] = '{8'hf0, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[11] = '{8'h9f, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[12] = '{8'h98, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[13] = '{8'h80, 1'b1, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[14] = '{8'hc3, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[15] = '{8'h41, 1'b0, 1'b1, 16'h0000, ERR_CONT};
    dir_rows[16] = '{8'he0, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[17] = '{8'h41, 1'b1, 1'b1, 16'h0000, ERR_TRUNC};
    dir_rows[18] = '{8'hf0, 1'b1, 1'b1, 16'h0000, ERR_TRUNC};
    dir_rows[19] = '{8'hed, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[20] = '{8'ha0, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[21] = '{8'h80, 1'b0, 1'b1, 16'h0000, ERR_SURR};
    dir_rows[22] = '{8'hf7, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[23] = '{8'hbf, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[24] = '{8'hbf, 1'b0, 1'b0, 16'h0000, ERR_NONE};
    dir_rows[25] = '{8'hbf, 1'b1, 1'b1, 16'h0000, ERR_RANGE};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_DIR_ROWS; i++) begin
      send_byte(dir_rows[i].byte_val, dir_rows[i].eos, !dir_rows[i].known_res);
      if (dir_rows[i].known_res)
        push_expect(dir_rows[i].exp_unit, dir_rows[i].exp_err, 1'b1, dir_rows[i].eos);
    end

    // Phases: free flow, idle sender, stalling receiver, then both at once.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 26; sink_stall_pct = 26; end
      endcase
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_random_string();
    end
    s_tvalid <= 1'b0;

    for (k = 0; k < 20000 && utf16_expect_q.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (utf16_expect_q.size() != 0) begin
      fail_cnt++;
      $display("%0t: %0d expected results never arrived", $time, utf16_expect_q.size());
    end

    $display("Sent %0d bytes in %0d strings under four flow-control mixes.",
             bytes_sent, strings_sent);
    $display("Checked %0d results: %0d errors, %0d surrogate pairs.",
             results_seen, error_results, pairs_seen);
    if (fail_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: utf8_to_utf16_transcoder.f
rtl/core/u2u_pkg.sv
rtl/core/u2u_front.sv
rtl/core/u2u_queue.sv
rtl/core/u2u_back.sv
rtl/core/utf8_to_utf16_transcoder.sv
tb/utf8_to_utf16_transcoder_tb.sv
